// File: sv/temperature_seven_segment_scanner_macros.svh
// Assertion macros shared by the temperature scanner RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef TEMPERATURE_SEVEN_SEGMENT_SCANNER_MACROS_SVH
`define TEMPERATURE_SEVEN_SEGMENT_SCANNER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TSS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tss assertion failed: same-cycle check");

// Next-cycle implication, disabled while reset is asserted.
`define TSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tss assertion failed: next-cycle check");

`endif

// File: sv/tss_pkg.sv
// Shared types, constants and the segment decode table for the temperature scanner.
// Depends on nothing; used by every module of the block.
package tss_pkg;

	// Display geometry.
	localparam int DIGIT_COUNT = 8;
	localparam int STORE_DEPTH = 8;
	localparam int POS_W       = 3;
	localparam int CODE_W      = 4;
	localparam int SPLIT_DIGITS = 5;
	localparam int FIRST_POS   = 3;
	localparam logic [POS_W-1:0] DP_POS = 3'd5;

	// Codes and masks.
	localparam logic [CODE_W-1:0] BLANK_CODE = 4'd10;
	localparam logic [7:0] DP_MASK  = 8'h7F;
	localparam logic [7:0] ALL_OFF  = 8'hFF;
	localparam logic [15:0] THRESHOLD_RESET = 16'd2600;

	typedef enum logic {
		CMD_SAMPLE = 1'b0,
		CMD_SCAN   = 1'b1
	} cmd_t;

	// Control passed from the pipeline to the display state.
	typedef struct packed {
		logic fire;
		cmd_t command;
	} step_t;

	typedef logic [SPLIT_DIGITS-1:0][CODE_W-1:0] digits_t;

	// Active-low segment pattern for a digit code; codes above nine are blank.
	function automatic logic [7:0] seg_decode(input logic [CODE_W-1:0] code);
		logic [7:0] seg;
		case (code)
			4'd0:    seg = 8'hC0;
			4'd1:    seg = 8'hF9;
			4'd2:    seg = 8'hA4;
			4'd3:    seg = 8'hB0;
			4'd4:    seg = 8'h99;
			4'd5:    seg = 8'h92;
			4'd6:    seg = 8'h82;
			4'd7:    seg = 8'hF8;
			4'd8:    seg = 8'h80;
			4'd9:    seg = 8'h90;
			default: seg = ALL_OFF;
		endcase
		return seg;
	endfunction

endpackage

// File: sv/tss_digit_split.sv
// Splits a 16-bit hundredths value into five decimal display codes.
// Depends on tss_pkg.
module tss_digit_split (
	input  logic [15:0]          value,
	output tss_pkg::digits_t     digits
);

	// Reciprocals, each exact for every 16-bit value with the given shift.
	localparam logic [32:0] RECIP_10    = 33'd52429;
	localparam logic [32:0] RECIP_100   = 33'd83887;
	localparam logic [32:0] RECIP_1000  = 33'd67109;
	localparam logic [32:0] RECIP_10000 = 33'd107375;

	function automatic logic [15:0] times_ten(input logic [15:0] x);
		return (x << 3) + (x << 1);
	endfunction

	logic [32:0] prod_10, prod_100, prod_1000, prod_10000;
	logic [12:0] quo_10;
	logic [9:0]  quo_100;
	logic [6:0]  quo_1000;
	logic [2:0]  quo_10000;
	logic [3:0]  dig_ones, dig_tens, dig_hundreds, dig_thousands;

	// Quotients by the powers of ten, all taken in parallel from the value.
	always_comb begin
		prod_10    = 33'(value) * RECIP_10;
		prod_100   = 33'(value) * RECIP_100;
		prod_1000  = 33'(value) * RECIP_1000;
		prod_10000 = 33'(value) * RECIP_10000;
		quo_10     = prod_10[31:19];
		quo_100    = prod_100[32:23];
		quo_1000   = prod_1000[32:26];
		quo_10000  = prod_10000[32:30];
	end

	// Each digit is the difference of neighboring quotients.
	always_comb begin
		dig_ones      = 4'(value - times_ten(16'(quo_10)));
		dig_tens      = 4'(16'(quo_10) - times_ten(16'(quo_100)));
		dig_hundreds  = 4'(16'(quo_100) - times_ten(16'(quo_1000)));
		dig_thousands = 4'(16'(quo_1000) - times_ten(16'(quo_10000)));
	end

	// Leading blanks above the hundreds place; at least "0.0x" is shown.
	always_comb begin
		digits[0] = (quo_10000 == 3'd0) ? tss_pkg::BLANK_CODE : 4'(quo_10000);
		digits[1] = (quo_1000 == 7'd0) ? tss_pkg::BLANK_CODE : dig_thousands;
		digits[2] = dig_hundreds;
		digits[3] = dig_tens;
		digits[4] = dig_ones;
	end

endmodule

// File: sv/tss_scan_core.sv
// Display state: digit store, scan position and alarm flag, with the per-word result logic.
// Depends on tss_pkg, tss_digit_split and the assertion macro header.
`include "temperature_seven_segment_scanner_macros.svh"

module tss_scan_core (
	input  logic                clk,
	input  logic                arst_n,
	input  tss_pkg::step_t      step,
	input  logic [15:0]         value,
	input  logic [15:0]         threshold,
	output logic [7:0]          segment_next,
	output logic [7:0]          enable_next,
	output logic                alarm_next
);

	logic [tss_pkg::STORE_DEPTH-1:0][tss_pkg::CODE_W-1:0] store_q;
	logic [tss_pkg::POS_W-1:0] pos_q;
	logic [tss_pkg::POS_W-1:0] pos_inc;
	logic                      alarm_q;
	tss_pkg::digits_t          digits;
	logic                      is_sample;
	logic [7:0]                seg_raw;

	tss_digit_split u_split (
		.value  (value),
		.digits (digits)
	);

	assign is_sample = (step.command == tss_pkg::CMD_SAMPLE);

	// Result of the current word: a sample blanks the outputs, a scan drives one position.
	always_comb begin
		seg_raw = tss_pkg::seg_decode(store_q[pos_q]);
		if (pos_q == tss_pkg::DP_POS) begin
			seg_raw = seg_raw & tss_pkg::DP_MASK;
		end
		if (is_sample) begin
			segment_next = tss_pkg::ALL_OFF;
			enable_next  = tss_pkg::ALL_OFF;
			alarm_next   = (value > threshold);
		end else begin
			segment_next = seg_raw;
			enable_next  = ~(8'd1 << pos_q);
			alarm_next   = alarm_q;
		end
	end

	// Next scan position, wrapping at the digit count.
	always_comb begin
		if (32'(pos_q) + 32'd1 >= 32'(tss_pkg::DIGIT_COUNT)) begin
			pos_inc = '0;
		end else begin
			pos_inc = pos_q + 3'd1;
		end
	end

	// State update once per word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < tss_pkg::STORE_DEPTH; i++) begin
				store_q[i] <= tss_pkg::BLANK_CODE;
			end
			pos_q   <= '0;
			alarm_q <= 1'b0;
		end else if (step.fire) begin
			alarm_q <= alarm_next;
			if (is_sample) begin
				for (int i = 0; i < tss_pkg::SPLIT_DIGITS; i++) begin
					store_q[tss_pkg::POS_W'(tss_pkg::FIRST_POS + i)] <= digits[i];
				end
			end else begin
				pos_q <= pos_inc;
			end
		end
	end

	`TSS_ASSERT_NOW(a_pos_in_range, clk, arst_n, 1'b1,
		32'(pos_q) < 32'(tss_pkg::DIGIT_COUNT))
	`TSS_ASSERT_NOW(a_low_positions_blank, clk, arst_n, 1'b1,
		(store_q[0] == tss_pkg::BLANK_CODE) && (store_q[1] == tss_pkg::BLANK_CODE))
	`TSS_ASSERT_NEXT(a_scan_moves_pos, clk, arst_n, step.fire && !is_sample,
		pos_q != $past(pos_q))
	`TSS_ASSERT_NEXT(a_sample_sets_alarm, clk, arst_n, step.fire && is_sample,
		alarm_q == ($past(value) > $past(threshold)))

endmodule

// File: sv/temperature_seven_segment_scanner.sv
// Temperature seven-segment scanner, top level.
// Input words arrive on a valid/ready channel: command selects a temperature
// sample (hundredths of a degree) or a display scan tick. Each input word
// yields exactly one output word on a valid/ready channel carrying the
// active-low segment pattern, the active-low digit select and the alarm LED.
// A sample updates the alarm flag and the five right-aligned digit codes and
// returns all-off segments and selects; a scan tick drives the current
// position (decimal point lit at position five) and then advances it.
// A word accepted into the input register is processed and moved into the result
// register when the result register is free or being read out.
// Throughput: one word per cycle while the receiver does not stall, set by the
// single processing stage between the input register and the result register.
// When the receiver stalls, the result register holds its word and the input
// register still takes one more word; ready drops only when both are full.
// The alarm threshold must be written through cfg_we/cfg_wdata only while the
// block is idle; the block does not enforce it. Reset clears both valid flags,
// blanks all digits, sets scan position and alarm to zero and threshold to 2600.
// Depends on tss_pkg, tss_scan_core and the assertion macro header.
`include "temperature_seven_segment_scanner_macros.svh"

module temperature_seven_segment_scanner (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        command,
	input  logic [15:0] temperature_hundredths,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  segment_pattern,
	output logic [7:0]  digit_enable,
	output logic        alarm_led,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	logic                valid_s1;
	tss_pkg::cmd_t       command_s1;
	logic [15:0]         value_s1;
	logic                valid_s2;
	logic [7:0]          segment_s2;
	logic [7:0]          enable_s2;
	logic                alarm_s2;
	logic [15:0]         threshold_q;
	logic                advance;
	tss_pkg::step_t      step;
	logic [7:0]          segment_next;
	logic [7:0]          enable_next;
	logic                alarm_next;

	// Handshake: the first stage moves on whenever the result register is free.
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	assign step.fire    = advance;
	assign step.command = command_s1;

	// Alarm threshold register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= tss_pkg::THRESHOLD_RESET;
		end else if (cfg_we) begin
			threshold_q <= cfg_wdata;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			command_s1 <= tss_pkg::cmd_t'(command);
			value_s1   <= temperature_hundredths;
		end
	end

	tss_scan_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.value        (value_s1),
		.threshold    (threshold_q),
		.segment_next (segment_next),
		.enable_next  (enable_next),
		.alarm_next   (alarm_next)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			segment_s2 <= segment_next;
			enable_s2  <= enable_next;
			alarm_s2   <= alarm_next;
		end
	end

	assign out_valid       = valid_s2;
	assign segment_pattern = segment_s2;
	assign digit_enable    = enable_s2;
	assign alarm_led       = alarm_s2;

	`TSS_ASSERT_NOW(a_select_onehot, clk, arst_n, valid_s2,
		$countones(~enable_s2) <= 1)
	`TSS_ASSERT_NEXT(a_stalled_word_kept, clk, arst_n, valid_s1 && !advance,
		valid_s1)
	`TSS_ASSERT_NEXT(a_advance_fills_result, clk, arst_n, advance,
		valid_s2)

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for the temperature seven-segment scanner.
// Depends on tss_pkg and the scanner RTL; predicts every result word in-line.
module testbench;

	// One input word and one result word as the bench sees them.
	typedef struct packed {
		tss_pkg::cmd_t cmd;
		logic [15:0]   temp;
	} scan_word_t;

	typedef struct packed {
		logic [7:0] seg;
		logic [7:0] sel;
		logic       alarm;
	} display_word_t;

	localparam int HOLD_OFF_CYCLES = 400;
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int SETTLE_CYCLES   = 4;

	// Active-low glyphs indexed by digit code; codes ten and up are dark.
	localparam logic [15:0][7:0] GLYPHS = {
		8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h90, 8'h80,
		8'hF8, 8'h82, 8'h92, 8'h99, 8'hB0, 8'hA4, 8'hF9, 8'hC0
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        command = 1'b0;
	logic [15:0] temperature_hundredths = 16'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  segment_pattern;
	logic [7:0]  digit_enable;
	logic        alarm_led;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = 16'd0;

	// Display model state.
	logic [3:0]  digit_codes [8];
	logic [2:0]  scan_pos_m;
	logic        alarm_m;
	logic [15:0] threshold_m;

	scan_word_t    pending_words [$];
	display_word_t expected_display [$];

	int fail_count = 0;
	int n_samples = 0;
	int n_ticks = 0;
	int n_lit = 0;
	int n_thresholds = 0;
	logic long_hold_req = 1'b0;

	temperature_seven_segment_scanner uut (
		.clk                    (clk),
		.arst_n                 (arst_n),
		.in_valid               (in_valid),
		.in_ready               (in_ready),
		.command                (command),
		.temperature_hundredths (temperature_hundredths),
		.out_valid              (out_valid),
		.out_ready              (out_ready),
		.segment_pattern        (segment_pattern),
		.digit_enable           (digit_enable),
		.alarm_led              (alarm_led),
		.cfg_we                 (cfg_we),
		.cfg_wdata              (cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Work out the result word for one accepted input word and update the model.
	function automatic display_word_t predict_display(scan_word_t w);
		display_word_t r;
		int unsigned v;
		v = w.temp;
		if (w.cmd == tss_pkg::CMD_SAMPLE) begin
			alarm_m = (w.temp > threshold_m);
			digit_codes[3] = (v >= 10000) ? 4'(v / 10000) : tss_pkg::BLANK_CODE;
			digit_codes[4] = (v >= 1000) ? 4'((v % 10000) / 1000) : tss_pkg::BLANK_CODE;
			digit_codes[5] = 4'((v % 1000) / 100);
			digit_codes[6] = 4'((v % 100) / 10);
			digit_codes[7] = 4'(v % 10);
			r.seg = tss_pkg::ALL_OFF;
			r.sel = tss_pkg::ALL_OFF;
		end else begin
			r.seg = GLYPHS[digit_codes[scan_pos_m]];
			// The decimal point is lit at its position even over a blank.
			if (scan_pos_m == tss_pkg::DP_POS)
				r.seg = r.seg & tss_pkg::DP_MASK;
			r.sel = ~(8'd1 << scan_pos_m);
			scan_pos_m = (int'(scan_pos_m) + 1 >= tss_pkg::DIGIT_COUNT) ?
				3'd0 : scan_pos_m + 3'd1;
		end
		r.alarm = alarm_m;
		return r;
	endfunction

	// Temperatures spread over every digit count, the boundaries and the threshold.
	function automatic logic [15:0] pick_temp();
		int t;
		case ($urandom_range(0, 7))
			0: t = $urandom_range(0, 9);
			1: t = $urandom_range(10, 99);
			2: t = $urandom_range(100, 999);
			3: t = $urandom_range(1000, 9999);
			4: t = $urandom_range(10000, 65535);
			5: begin
				case ($urandom_range(0, 9))
					0: t = 0;
					1: t = 9;
					2: t = 10;
					3: t = 99;
					4: t = 100;
					5: t = 999;
					6: t = 1000;
					7: t = 9999;
					8: t = 10000;
					default: t = 65535;
				endcase
			end
			6: begin
				t = int'(threshold_m) + int'($urandom_range(0, 2)) - 1;
				if (t < 0)
					t = 0;
				if (t > 65535)
					t = 65535;
			end
			default: t = $urandom & 16'hFFFF;
		endcase
		return 16'(t);
	endfunction

	task automatic queue_word(tss_pkg::cmd_t cmd, logic [15:0] temp);
		scan_word_t w;
		w.cmd = cmd;
		w.temp = temp;
		pending_words.push_back(w);
	endtask

	task automatic queue_ticks(int count);
		for (int i = 0; i < count; i++)
			queue_word(tss_pkg::CMD_SCAN, 16'($urandom));
	endtask

	// Mostly a sample followed by a run of ticks, with some loose words mixed in.
	task automatic queue_random(int target);
		int made;
		int k;
		made = 0;
		while (made < target) begin
			if ($urandom_range(0, 9) < 7) begin
				k = $urandom_range(1, 10);
				queue_word(tss_pkg::CMD_SAMPLE, pick_temp());
				queue_ticks(k);
				made += 1 + k;
			end else begin
				queue_word(tss_pkg::cmd_t'($urandom_range(0, 1)), 16'($urandom));
				made++;
			end
		end
	endtask

	// Wait until nothing is pending, offered or outstanding, then let the pipe settle.
	task automatic wait_until_drained();
		while (pending_words.size() != 0 || in_valid || expected_display.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_threshold(logic [15:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		threshold_m = value;
		n_thresholds++;
	endtask

	// Sender: bursts of words from the pending queue with random gaps.
	int burst_left = 8;
	int gap_left = 0;
	scan_word_t offered = '0;

	always @(posedge clk) begin
		logic next_valid;
		scan_word_t next_word;
		next_valid = in_valid;
		next_word = offered;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				expected_display.push_back(predict_display(offered));
				if (offered.cmd == tss_pkg::CMD_SAMPLE)
					n_samples++;
				else
					n_ticks++;
				next_valid = 1'b0;
			end
			if (!next_valid) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_words.size() != 0) begin
					next_word = pending_words.pop_front();
					next_valid = 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						if ($urandom_range(0, 4) == 0) begin
							burst_left = 150;
							gap_left = 0;
						end else begin
							burst_left = $urandom_range(1, 48);
							gap_left = ($urandom_range(0, 3) == 0) ?
								0 : $urandom_range(1, 12);
						end
					end
				end
			end
		end
		in_valid <= next_valid;
		offered <= next_word;
		command <= next_word.cmd;
		temperature_hundredths <= next_word.temp;
	end

	// Receiver: checks each result word and stalls on a pattern of its own.
	int rx_cycle = 0;
	int rx_mode = 0;
	int hold_left = 0;
	logic hold_used = 1'b0;

	always @(posedge clk) begin
		display_word_t got;
		display_word_t want;
		logic next_ready;
		next_ready = 1'b1;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got.seg = segment_pattern;
				got.sel = digit_enable;
				got.alarm = alarm_led;
				if (got.alarm)
					n_lit++;
				if (expected_display.size() == 0) begin
					$error("unexpected word: segment_pattern=%02h digit_enable=%02h",
						got.seg, got.sel);
					fail_count++;
				end else begin
					want = expected_display.pop_front();
					if (got.seg !== want.seg) begin
						$error("segment_pattern: expected %02h, got %02h",
							want.seg, got.seg);
						fail_count++;
					end
					if (got.sel !== want.sel) begin
						$error("digit_enable: expected %02h, got %02h",
							want.sel, got.sel);
						fail_count++;
					end
					if (got.alarm !== want.alarm) begin
						$error("alarm_led: expected %0b, got %0b",
							want.alarm, got.alarm);
						fail_count++;
					end
				end
			end
			rx_cycle++;
			if (long_hold_req && !hold_used) begin
				hold_left = HOLD_OFF_CYCLES;
				hold_used = 1'b1;
			end
			if (rx_cycle % 64 == 0)
				rx_mode = $urandom_range(0, 3);
			if (hold_left > 0) begin
				hold_left--;
				next_ready = 1'b0;
			end else begin
				case (rx_mode)
					0: next_ready = 1'b1;
					1: next_ready = $urandom_range(0, 1);
					2: next_ready = ($urandom_range(0, 4) != 0);
					default: next_ready = (rx_cycle % 7 != 3);
				endcase
			end
		end
		out_ready <= next_ready;
	end

	// Watchdog on cycles in which no word moves on either channel.
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		for (int i = 0; i < 8; i++)
			digit_codes[i] = tss_pkg::BLANK_CODE;
		scan_pos_m = '0;
		alarm_m = 1'b0;
		threshold_m = tss_pkg::THRESHOLD_RESET;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Blank display after reset with the point at position five, then the
		// widest value and a value under ten, each scanned through a full wrap.
		queue_ticks(8);
		queue_word(tss_pkg::CMD_SAMPLE, 16'd65535);
		queue_ticks(8);
		queue_word(tss_pkg::CMD_SAMPLE, 16'd5);
		queue_ticks(8);
		queue_random(120);

		// Lowest threshold: anything above zero lights the alarm.
		wait_until_drained();
		write_threshold(16'd0);
		queue_word(tss_pkg::CMD_SAMPLE, 16'd0);
		queue_ticks(1);
		queue_word(tss_pkg::CMD_SAMPLE, 16'd1);
		queue_random(140);

		// Highest threshold, with a long receiver hold-off while words keep coming.
		wait_until_drained();
		write_threshold(16'd65535);
		long_hold_req = 1'b1;
		queue_random(160);

		// Random threshold; the sender pauses midway until every result is back.
		wait_until_drained();
		write_threshold(16'($urandom));
		queue_random(140);
		wait_until_drained();
		queue_random(100);

		// Threshold near its reset value.
		wait_until_drained();
		write_threshold(16'($urandom_range(2500, 2700)));
		queue_random(160);

		wait_until_drained();
		if (expected_display.size() != 0)
			fail_count++;
		$display("Covered %0d samples and %0d scan ticks under %0d written thresholds.",
			n_samples, n_ticks, n_thresholds);
		$display("%0d result words carried a lit alarm; one %0d-cycle receiver hold-off.",
			n_lit, HOLD_OFF_CYCLES);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
